>>> design/u16d_pkg.sv
// Shared types and constants for the UTF-16 decoder with byte order mark detection.
`timescale 1ns / 1ps
`default_nettype none
package u16d_pkg;

	// byte order codes
	localparam logic [1:0] ORDER_NONE   = 2'd0;
	localparam logic [1:0] ORDER_BIG    = 2'd1;
	localparam logic [1:0] ORDER_LITTLE = 2'd2;

	// configuration register indexes
	localparam int          CFG_IDX_W          = 1;
	localparam int          CFG_DATA_W         = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ORDER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_ORDER = 1'd1;

	// byte order marks, big endian view
	localparam logic [15:0] BOM_BIG    = 16'hfeff;
	localparam logic [15:0] BOM_LITTLE = 16'hfffe;

	// surrogate prefixes (top six bits)
	localparam logic [5:0] SURR_HIGH = 6'b110110;
	localparam logic [5:0] SURR_LOW  = 6'b110111;

	localparam logic [2:0] BAD_LEN_NONE  = 3'd0;
	localparam logic [2:0] BAD_LEN_SHORT = 3'd2;
	localparam logic [2:0] BAD_LEN_LONG  = 3'd4;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef enum logic [1:0] {
		OP_UNIT  = 2'd0,	// one decoded unit
		OP_PAIR  = 2'd1,	// high then low surrogate
		OP_BAD2  = 2'd2,	// unpaired low surrogate
		OP_BAD4  = 2'd3		// high surrogate not followed by low
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [15:0] unit_a;
		logic [15:0] unit_b;
	} op_entry_t;

	// back to queue
	typedef struct packed {
		logic pop;
	} q_req_t;

	// queue to back
	typedef struct packed {
		logic      empty;
		op_entry_t head;
	} q_rsp_t;

endpackage
`default_nettype wire

>>> design/utf16_decoder_with_bom.sv
// Top level of the UTF-16 decoder with byte order mark detection.
// A unit accepted on the input is written into the queue, then loaded into the output register.
// Input takes one unit per cycle while not full; a surrogate pair gives two result transfers at the back.
// Items that give no result (mark, held high surrogate) use an input transfer but queue nothing.
// Reset (arst_n low, asynchronous): order undecided, fallback big endian, queue and
// output empty, no surrogate held. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module utf16_decoder_with_bom
	import u16d_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration writes (index 0 expected_order, 1 fallback_order)
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// input side: transfer when push && !full
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [7:0]            first_byte,
	input  wire logic [7:0]            second_byte,
	input  wire logic                  restart,
	// result side: transfer when pop && !empty
	output logic                       empty,
	input  wire logic                  pop,
	output logic [15:0]                code_unit,
	output logic                       status,
	output logic [2:0]                 bad_length,
	output logic                       last
);

	logic      accept;
	logic      op_valid;
	op_entry_t op_entry;
	q_req_t    q_req;
	q_rsp_t    q_rsp;

	// Front end keeps byte order and surrogate state; it advances on every
	// input transfer and drops at most one op into the queue.
	assign accept = push && !full;

	u16d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.first_byte  (first_byte),
		.second_byte (second_byte),
		.restart     (restart),
		.op_valid    (op_valid),
		.op_entry    (op_entry)
	);

	// full backpressures input only when the queue holds QDEPTH ops, so a
	// stalled result port does not stop input until the queue fills.
	u16d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept && op_valid),
		.wr_entry (op_entry),
		.full     (full),
		.req      (q_req),
		.rsp      (q_rsp)
	);

	// Back end pulls one op, registers its first result, and for a pair
	// keeps the low surrogate for the next load of the output register.
	u16d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rsp        (q_rsp),
		.req        (q_req),
		.pop        (pop),
		.empty      (empty),
		.code_unit  (code_unit),
		.status     (status),
		.bad_length (bad_length),
		.last       (last)
	);

endmodule
`default_nettype wire

>>> design/u16d_front.sv
// Front end: configuration, byte order tracking, surrogate pairing, op generation.
`timescale 1ns / 1ps
`default_nettype none
module u16d_front
	import u16d_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  accept,
	input  wire logic [7:0]            first_byte,
	input  wire logic [7:0]            second_byte,
	input  wire logic                  restart,
	output logic                       op_valid,
	output op_entry_t                  op_entry
);

	logic [1:0]  expected_order_q;
	logic [1:0]  fallback_order_q;
	logic [1:0]  cur_order_q;
	logic        held_valid_q;
	logic [15:0] held_high_q;

	logic [1:0]  order_eff;
	logic        held_eff;
	logic [15:0] raw;
	logic        mark;
	logic [1:0]  order_next;
	logic [15:0] unit;
	logic        is_high;
	logic        is_low;
	logic        hold_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_order_q <= ORDER_NONE;
			fallback_order_q <= ORDER_BIG;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXPECTED_ORDER: expected_order_q <= cfg_wdata;
				CFG_FALLBACK_ORDER: fallback_order_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		order_eff  = restart ? expected_order_q : cur_order_q;
		held_eff   = restart ? 1'b0 : held_valid_q;
		raw        = {first_byte, second_byte};
		mark       = 1'b0;
		order_next = order_eff;
		if (order_eff == ORDER_NONE) begin
			if (raw == BOM_BIG) begin
				mark       = 1'b1;
				order_next = ORDER_BIG;
			end else if (raw == BOM_LITTLE) begin
				mark       = 1'b1;
				order_next = ORDER_LITTLE;
			end else begin
				order_next = (fallback_order_q == ORDER_BIG) ? ORDER_BIG : ORDER_LITTLE;
			end
		end
		unit    = (order_next == ORDER_BIG) ? {first_byte, second_byte}
		                                    : {second_byte, first_byte};
		is_high = (unit[15:10] == SURR_HIGH);
		is_low  = (unit[15:10] == SURR_LOW);

		op_valid        = 1'b0;
		op_entry.kind   = OP_UNIT;
		op_entry.unit_a = unit;
		op_entry.unit_b = unit;
		hold_next       = held_eff;
		if (!mark) begin
			if (held_eff) begin
				hold_next       = 1'b0;
				op_valid        = 1'b1;
				op_entry.kind   = is_low ? OP_PAIR : OP_BAD4;
				op_entry.unit_a = held_high_q;
			end else if (is_high) begin
				hold_next = 1'b1;
			end else begin
				op_valid      = 1'b1;
				op_entry.kind = is_low ? OP_BAD2 : OP_UNIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_order_q  <= ORDER_NONE;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			cur_order_q  <= order_next;
			held_valid_q <= hold_next;
		end
	end

	// held value only matters while held_valid_q is set
	always_ff @(posedge clk) begin
		if (accept && !mark && !held_eff && is_high)
			held_high_q <= unit;
	end

endmodule
`default_nettype wire

>>> design/u16d_queue.sv
// Short op queue decoupling the front end from the result stage.
`timescale 1ns / 1ps
`default_nettype none
module u16d_queue
	import u16d_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  wire op_entry_t wr_entry,
	output logic           full,
	input  wire q_req_t    req,
	output q_rsp_t         rsp
);

	op_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_wr;
	logic               do_rd;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign rsp.empty = (count_q == '0);
	assign rsp.head  = mem_q[rd_ptr_q];
	assign do_wr     = wr_en && !full;
	assign do_rd     = req.pop && !rsp.empty;

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> design/u16d_back.sv
// Result stage: expands queued ops into result transfers through an output register.
`timescale 1ns / 1ps
`default_nettype none
module u16d_back
	import u16d_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire q_rsp_t rsp,
	output q_req_t      req,
	input  wire logic   pop,
	output logic        empty,
	output logic [15:0] code_unit,
	output logic        status,
	output logic [2:0]  bad_length,
	output logic        last
);

	logic        out_valid_q;
	logic [15:0] code_unit_q;
	logic        status_q;
	logic [2:0]  bad_length_q;
	logic        last_q;
	logic        pend_valid_q;
	logic [15:0] pend_unit_q;

	logic load;
	logic take;

	assign empty      = !out_valid_q;
	assign code_unit  = code_unit_q;
	assign status     = status_q;
	assign bad_length = bad_length_q;
	assign last       = last_q;

	// output slot frees when empty or being taken this cycle
	assign load    = !out_valid_q || pop;
	assign take    = load && !pend_valid_q && !rsp.empty;
	assign req.pop = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q  <= pend_valid_q || !rsp.empty;
			pend_valid_q <= take && (rsp.head.kind == OP_PAIR);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				code_unit_q  <= pend_unit_q;
				status_q     <= 1'b0;
				bad_length_q <= BAD_LEN_NONE;
				last_q       <= 1'b1;
			end else if (take) begin
				unique case (rsp.head.kind)
					OP_UNIT: begin
						code_unit_q  <= rsp.head.unit_a;
						status_q     <= 1'b0;
						bad_length_q <= BAD_LEN_NONE;
						last_q       <= 1'b1;
					end
					OP_PAIR: begin
						code_unit_q  <= rsp.head.unit_a;
						status_q     <= 1'b0;
						bad_length_q <= BAD_LEN_NONE;
						last_q       <= 1'b0;
					end
					OP_BAD2: begin
						code_unit_q  <= '0;
						status_q     <= 1'b1;
						bad_length_q <= BAD_LEN_SHORT;
						last_q       <= 1'b1;
					end
					OP_BAD4: begin
						code_unit_q  <= '0;
						status_q     <= 1'b1;
						bad_length_q <= BAD_LEN_LONG;
						last_q       <= 1'b1;
					end
				endcase
			end
			if (take)
				pend_unit_q <= rsp.head.unit_b;
		end
	end

endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for the UTF-16 decoder with byte order mark detection.
`timescale 1ns / 1ps
module tb;
	import u16d_pkg::*;

	// status codes on the result side
	localparam logic ST_OK  = 1'b0;
	localparam logic ST_BAD = 1'b1;
	// order code outside the named set; decodes as little endian
	localparam logic [1:0] ORDER_ALT = 2'd3;

	// one code unit as it enters the block
	typedef struct packed {
		logic [7:0] b1;
		logic [7:0] b2;
		logic       rs;
	} unit_in_t;

	// one decoded result
	typedef struct packed {
		logic [15:0] cu;
		logic        st;
		logic [2:0]  blen;
		logic        lst;
	} decoded_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	logic       push = 1'b0;
	logic       full;
	logic [7:0] first_byte = '0;
	logic [7:0] second_byte = '0;
	logic       restart = 1'b0;

	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] code_unit;
	logic        status;
	logic [2:0]  bad_length;
	logic        last;

	utf16_decoder_with_bom i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.push        (push),
		.full        (full),
		.first_byte  (first_byte),
		.second_byte (second_byte),
		.restart     (restart),
		.empty       (empty),
		.pop         (pop),
		.code_unit   (code_unit),
		.status      (status),
		.bad_length  (bad_length),
		.last        (last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow of the decoder: register copies plus order and held surrogate
	// ------------------------------------------------------------------
	logic [1:0]  cfg_expected = ORDER_NONE;
	logic [1:0]  cfg_fallback = ORDER_BIG;
	logic [1:0]  ord_now = ORDER_NONE;
	logic [15:0] held_unit = '0;
	logic        held_ok = 1'b0;

	unit_in_t unit_q[$];	// units waiting for the driver
	decoded_t want_q[$];	// results still owed by the block
	int       errors = 0;

	// idle switches, changed only between phases
	bit src_idle_on = 1'b1;
	bit snk_idle_on = 1'b1;

	task automatic flag(string msg);
		errors++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic emit(logic [15:0] cu, logic st, logic [2:0] blen, logic lst);
		decoded_t d;
		d.cu = cu;
		d.st = st;
		d.blen = blen;
		d.lst = lst;
		want_q.push_back(d);
	endtask

	// Work out what one accepted code unit produces.
	task automatic decode_unit(logic [7:0] b1, logic [7:0] b2, logic rs);
		logic [15:0] raw;
		logic [15:0] cu;
		raw = {b1, b2};
		if (rs) begin
			ord_now = cfg_expected;
			held_unit = '0;
			held_ok = 1'b0;
		end
		// undecided: a mark is swallowed, anything else takes the fallback
		if (ord_now == ORDER_NONE) begin
			if (raw == BOM_BIG) begin
				ord_now = ORDER_BIG;
				return;
			end
			if (raw == BOM_LITTLE) begin
				ord_now = ORDER_LITTLE;
				return;
			end
			ord_now = (cfg_fallback == ORDER_BIG) ? ORDER_BIG : ORDER_LITTLE;
		end
		// only code 1 is big endian; 2 and 3 both swap
		cu = (ord_now == ORDER_BIG) ? {b1, b2} : {b2, b1};
		if (held_ok) begin
			held_ok = 1'b0;
			if (cu[15:10] == SURR_LOW) begin
				emit(held_unit, ST_OK, BAD_LEN_NONE, 1'b0);
				emit(cu, ST_OK, BAD_LEN_NONE, 1'b1);
			end else begin
				emit('0, ST_BAD, BAD_LEN_LONG, 1'b1);
			end
			held_unit = '0;
			return;
		end
		if (cu[15:10] == SURR_HIGH) begin
			held_unit = cu;
			held_ok = 1'b1;
		end else if (cu[15:10] == SURR_LOW) begin
			emit('0, ST_BAD, BAD_LEN_SHORT, 1'b1);
		end else begin
			emit(cu, ST_OK, BAD_LEN_NONE, 1'b1);
		end
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap(bit on);
		int r;
		if (!on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// ------------------------------------------------------------------
	// Driver: one unit per transfer, fields held while full stalls us
	// ------------------------------------------------------------------
	int gap_left = 0;

	always @(posedge clk) begin : drive
		unit_in_t it;
		if (arst_n) begin
			if (push && !full)
				decode_unit(first_byte, second_byte, restart);
			if (!(push && full)) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (unit_q.size() > 0) begin
					it = unit_q.pop_front();
					first_byte <= it.b1;
					second_byte <= it.b2;
					restart <= it.rs;
					push <= 1'b1;
					gap_left = pick_gap(src_idle_on);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every result transfer is checked against the oldest owed one
	// ------------------------------------------------------------------
	int stall_left = 0;

	always @(posedge clk) begin : sink
		decoded_t w;
		if (arst_n) begin
			if (pop && !empty) begin
				if (want_q.size() == 0) begin
					flag($sformatf("unexpected result unit=%h status=%0b len=%0d last=%0b",
						code_unit, status, bad_length, last));
				end else begin
					w = want_q.pop_front();
					if (code_unit !== w.cu)
						flag($sformatf("code_unit %h, want %h", code_unit, w.cu));
					if (status !== w.st)
						flag($sformatf("status %0b, want %0b", status, w.st));
					if (bad_length !== w.blen)
						flag($sformatf("bad_length %0d, want %0d", bad_length, w.blen));
					if (last !== w.lst)
						flag($sformatf("last %0b, want %0b", last, w.lst));
				end
				stall_left = pick_gap(snk_idle_on);
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	bit fresh = 1'b0;	// restart flag for the next queued unit
	int gen_count = 0;

	task automatic put(logic [7:0] b1, logic [7:0] b2, logic rs);
		unit_in_t it;
		it.b1 = b1;
		it.b2 = b2;
		it.rs = rs;
		unit_q.push_back(it);
	endtask

	task automatic add_raw(logic [7:0] b1, logic [7:0] b2);
		put(b1, b2, fresh);
		fresh = 1'b0;
		gen_count++;
	endtask

	task automatic add_unit(bit le, logic [15:0] cu);
		if (le)
			add_raw(cu[7:0], cu[15:8]);
		else
			add_raw(cu[15:8], cu[7:0]);
	endtask

	// Messages: restart, optional mark, then units in the order that the
	// block will use. A small share is noise that ignores the framing.
	task automatic gen_traffic(int n);
		int target;
		int k;
		int r;
		bit le;
		logic [15:0] cu;
		target = gen_count + n;
		while (gen_count < target) begin
			fresh = 1'b1;
			if (cfg_expected == ORDER_NONE) begin
				case ($urandom_range(0, 2))
					0: begin
						add_unit(1'b0, BOM_BIG);
						le = 1'b0;
					end
					1: begin
						add_unit(1'b0, BOM_LITTLE);
						le = 1'b1;
					end
					default: le = (cfg_fallback != ORDER_BIG);
				endcase
			end else begin
				le = (cfg_expected != ORDER_BIG);
			end
			k = $urandom_range(1, 12);
			for (int i = 0; i < k; i++) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					add_unit(le, 16'($urandom_range(0, 65535)));
				end else if (r < 70) begin
					add_unit(le, {SURR_HIGH, 10'($urandom_range(0, 1023))});
					add_unit(le, {SURR_LOW, 10'($urandom_range(0, 1023))});
				end else if (r < 77) begin
					add_unit(le, {SURR_LOW, 10'($urandom_range(0, 1023))});
				end else if (r < 84) begin
					// high surrogate broken by anything but a low one
					add_unit(le, {SURR_HIGH, 10'($urandom_range(0, 1023))});
					cu = 16'($urandom_range(0, 65535));
					if (cu[15:10] == SURR_LOW)
						cu[10] = 1'b0;
					add_unit(le, cu);
				end else if (r < 88) begin
					// dangling high, dropped by the next restart
					add_unit(le, {SURR_HIGH, 10'($urandom_range(0, 1023))});
					break;
				end else if (r < 93) begin
					add_unit(le, $urandom_range(0, 1) ? BOM_BIG : BOM_LITTLE);
				end else begin
					fresh = ($urandom_range(0, 15) == 0);
					add_raw(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		// current order is left alone; only a restart picks this up
		if (idx == CFG_EXPECTED_ORDER)
			cfg_expected = val;
		else
			cfg_fallback = val;
	endtask

	// Drain: all units sent, all results back, then idle clocks as slack
	// for units that leave nothing behind (marks, held surrogates).
	task automatic settle();
		int n;
		@(posedge clk);
		while (unit_q.size() > 0 || push)
			@(posedge clk);
		n = 0;
		while (want_q.size() > 0 && n < 2000) begin
			@(posedge clk);
			n++;
		end
		if (want_q.size() > 0) begin
			flag($sformatf("%0d results never arrived", want_q.size()));
			want_q.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// register settings per phase, extremes included
	logic [1:0] exp_tab [6] = '{ORDER_NONE, ORDER_BIG, ORDER_LITTLE, ORDER_ALT,
		ORDER_NONE, ORDER_NONE};
	logic [1:0] fb_tab [6] = '{ORDER_LITTLE, ORDER_NONE, ORDER_ALT, ORDER_BIG,
		ORDER_NONE, ORDER_ALT};

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with reset values: undecided order, big endian fallback.
		put(8'hfe, 8'hff, 1'b0);	// big endian mark, swallowed
		put(8'h00, 8'h00, 1'b0);
		put(8'hff, 8'hff, 1'b0);
		put(8'hd8, 8'h00, 1'b0);	// lowest pair
		put(8'hdc, 8'h00, 1'b0);
		put(8'hdb, 8'hff, 1'b0);	// highest pair
		put(8'hdf, 8'hff, 1'b0);
		put(8'hdb, 8'hff, 1'b0);	// high then plain unit
		put(8'h00, 8'h41, 1'b0);
		put(8'hd8, 8'h00, 1'b0);	// high then high
		put(8'hdb, 8'hff, 1'b0);
		put(8'hdc, 8'h00, 1'b0);	// lone low
		put(8'hfe, 8'hff, 1'b0);	// mark once order is set: plain unit
		put(8'hff, 8'hfe, 1'b1);	// restart, little endian mark
		put(8'h41, 8'h00, 1'b0);
		put(8'h00, 8'hd8, 1'b0);	// held high...
		put(8'h41, 8'h00, 1'b1);	// ...dropped by restart, fallback taken
		put(8'h00, 8'hdc, 1'b1);
		put(8'hfe, 8'hff, 1'b1);
		put(8'hd7, 8'hff, 1'b0);	// just below surrogates
		put(8'he0, 8'h00, 1'b0);	// just above
		put(8'hdf, 8'hff, 1'b0);
		put(8'hd8, 8'h00, 1'b0);	// held high, then restart on a high unit
		put(8'hd8, 8'h00, 1'b1);
		put(8'hdc, 8'h00, 1'b0);
		gen_traffic(200);
		settle();

		for (int p = 0; p < 6; p++) begin
			write_reg(CFG_EXPECTED_ORDER, exp_tab[p]);
			write_reg(CFG_FALLBACK_ORDER, fb_tab[p]);
			// some phases run with no idling on one side or both
			src_idle_on = ($urandom_range(0, 2) != 0);
			snk_idle_on = ($urandom_range(0, 2) != 0);
			gen_traffic(200);
			settle();
		end

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#6000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> filelist.f
design/u16d_pkg.sv
design/u16d_front.sv
design/u16d_queue.sv
design/u16d_back.sv
design/utf16_decoder_with_bom.sv
bench/tb.sv
